// ===== hdl/etmb_pkg.sv =====
// ----------------------------------------------------------------------------
// etmb_pkg
// Types, constants and arithmetic helpers of the Euler transform builder.
// ----------------------------------------------------------------------------
package etmb_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;

  localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032875;
  localparam logic        [33:0] DEG_TO_RAD   = 34'd9595049034;
  localparam logic        [16:0] QUARTER_TURN = 17'd11520;
  localparam logic        [16:0] HALF_TURN    = 17'd23040;
  localparam logic signed [35:0] ONE_Q30      = 36'sd1073741824;
  localparam logic signed [31:0] UNIT_SCALE   = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] m_c0_r0;
    logic signed [31:0] m_c0_r1;
    logic signed [31:0] m_c0_r2;
    logic signed [31:0] m_c1_r0;
    logic signed [31:0] m_c1_r1;
    logic signed [31:0] m_c1_r2;
    logic signed [31:0] m_c2_r0;
    logic signed [31:0] m_c2_r1;
    logic signed [31:0] m_c2_r2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } result_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
  } ctx_t;

  function automatic logic signed [33:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      default: v = 32'h0000007F;
    endcase
    return $signed({2'b00, v});
  endfunction

  function automatic logic signed [35:0] mulq(input logic signed [35:0] a,
                                              input logic signed [35:0] b);
    logic signed [71:0] p;
    p = a * b;
    p = p + 72'sd536870912;
    return p[65:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scale_q(input logic signed [35:0] r,
                                                 input logic signed [31:0] s);
    logic signed [67:0] p;
    p = r * s;
    p = p + 68'sd536870912;
    p = p >>> 30;
    return sat32(p[65:0]);
  endfunction

  function automatic logic signed [63:0] cam_term(input logic signed [31:0] m,
                                                  input logic signed [31:0] x);
    logic signed [63:0] p;
    p = m * x;
    p = p + (64'sd1 <<< (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

endpackage

// ===== hdl/etmb_item_if.sv =====
// ----------------------------------------------------------------------------
// etmb_item_if
// Request channel: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface etmb_item_if import etmb_pkg::*;;
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/etmb_result_if.sv =====
// ----------------------------------------------------------------------------
// etmb_result_if
// Result channel: valid, ready and one 3x4 transform.
// ----------------------------------------------------------------------------
interface etmb_result_if import etmb_pkg::*;;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/etmb_cordic.sv =====
// ----------------------------------------------------------------------------
// etmb_cordic
// Half-angle quadrant reduction and pipelined rotation CORDIC, one stage per
// iteration; gives the signed cosine and sine in Q30.
// ----------------------------------------------------------------------------
module etmb_cordic import etmb_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [32:0] cos_q,
  output logic signed [32:0] sin_q
);

  logic signed [33:0] zs [0:CORDIC_STEPS-1];
  logic signed [32:0] xs [0:CORDIC_STEPS-1];
  logic signed [32:0] ys [0:CORDIC_STEPS-1];
  logic               nc [0:CORDIC_STEPS];
  logic               ns [0:CORDIC_STEPS];

  logic [16:0] mag;
  logic [13:0] red;
  logic        red_nc;
  logic        red_ns;
  logic [47:0] zprod;

  always_comb begin
    mag = angle[15] ? 17'(-$signed({angle[15], angle})) : {1'b0, angle};
    if (mag <= QUARTER_TURN) begin
      red    = mag[13:0];
      red_nc = 1'b0;
      red_ns = 1'b0;
    end else if (mag <= HALF_TURN) begin
      red    = 14'(HALF_TURN - mag);
      red_nc = 1'b1;
      red_ns = 1'b0;
    end else begin
      red    = 14'(mag - HALF_TURN);
      red_nc = 1'b1;
      red_ns = 1'b1;
    end
    zprod = 48'(red) * 48'(DEG_TO_RAD) + 48'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= $signed({2'b00, zprod[47:16]});
      nc[0] <= red_nc;
      ns[0] <= red_ns ^ angle[15];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [32:0] xin;
    logic signed [32:0] yin;
    logic               dir;

    if (i == 0) begin : g_first
      assign xin = CORDIC_GAIN;
      assign yin = '0;
    end else begin : g_rest
      assign xin = xs[i-1];
      assign yin = ys[i-1];
    end

    assign dir = ~zs[i][33];

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i]   <= dir ? xin - (yin >>> i) : xin + (yin >>> i);
        ys[i]   <= dir ? yin + (xin >>> i) : yin - (xin >>> i);
        nc[i+1] <= nc[i];
        ns[i+1] <= ns[i];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          zs[i+1] <= dir ? zs[i] - atan_q30(i) : zs[i] + atan_q30(i);
        end
      end
    end
  end

  assign cos_q = nc[CORDIC_STEPS] ? -xs[CORDIC_STEPS-1] : xs[CORDIC_STEPS-1];
  assign sin_q = ns[CORDIC_STEPS] ? -ys[CORDIC_STEPS-1] : ys[CORDIC_STEPS-1];

endmodule

// ===== hdl/euler_transform_matrix_builder.sv =====
// ----------------------------------------------------------------------------
// euler_transform_matrix_builder
// Builds a 3x4 model or camera transform from position, scale and Euler
// angles: CORDIC half-angle sin/cos, quaternion, rotation matrix, scaling.
//
//   channel  dir  carries
//   item     in   action, position, scale, three angles
//   result   out  scaled 3x3 (column major) and translation
//
// One request per cycle unless stalled; the stages are the input register,
// reduction, one stage per CORDIC iteration and eight multiply/sum stages.
// The whole pipeline advances together; it holds when the output register is
// full and not taken. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module euler_transform_matrix_builder import etmb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  etmb_item_if.sink    item,
  etmb_result_if.source result
);

  localparam int Q1   = CORDIC_STEPS + 2;
  localparam int LAST = Q1 + 7;

  logic       en;
  logic       vld [0:LAST];
  ctx_t       ctx [0:LAST-1];
  item_t      inr;

  logic signed [32:0] c1, s1, c2, s2, c3, s3;

  logic signed [35:0] c1c2, s1s2, s1c2, c1s2, c3r, s3r;
  logic signed [35:0] a0, a1, a2, a3, a4, a5, a6, a7;
  logic signed [35:0] qw, qx, qy, qz;
  logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [35:0] rm [0:8];
  logic signed [31:0] mm [0:8];
  logic signed [31:0] mt [0:8];
  logic signed [63:0] tp [0:8];
  result_t            outr;

  assign en          = !vld[LAST] || result.ready;
  assign item.ready  = en;
  assign result.valid = vld[LAST];
  assign result.data = outr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= item.valid;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr            <= item.data;
      ctx[0].action  <= item.data.action;
      ctx[0].pos_x   <= item.data.pos_x;
      ctx[0].pos_y   <= item.data.pos_y;
      ctx[0].pos_z   <= item.data.pos_z;
      ctx[0].scale_x <= item.data.scale_x;
      ctx[0].scale_y <= item.data.scale_y;
      for (int k = 1; k < LAST; k++) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  etmb_cordic u_cordic_x (.clk, .en, .angle(inr.rot_x), .cos_q(c3), .sin_q(s3));
  etmb_cordic u_cordic_y (.clk, .en, .angle(inr.rot_y), .cos_q(c1), .sin_q(s1));
  etmb_cordic u_cordic_z (.clk, .en, .angle(inr.rot_z), .cos_q(c2), .sin_q(s2));

  always_ff @(posedge clk) begin
    if (en) begin
      c1c2 <= mulq(36'(c1), 36'(c2));
      s1s2 <= mulq(36'(s1), 36'(s2));
      s1c2 <= mulq(36'(s1), 36'(c2));
      c1s2 <= mulq(36'(c1), 36'(s2));
      c3r  <= 36'(c3);
      s3r  <= 36'(s3);

      a0 <= mulq(c1c2, c3r);
      a1 <= mulq(s1s2, s3r);
      a2 <= mulq(c1c2, s3r);
      a3 <= mulq(s1s2, c3r);
      a4 <= mulq(s1c2, c3r);
      a5 <= mulq(c1s2, s3r);
      a6 <= mulq(c1s2, c3r);
      a7 <= mulq(s1c2, s3r);

      qw <= a0 - a1;
      qx <= a2 + a3;
      qy <= a4 + a5;
      qz <= a6 - a7;

      xx <= mulq(qx, qx);
      yy <= mulq(qy, qy);
      zz <= mulq(qz, qz);
      xy <= mulq(qx, qy);
      xz <= mulq(qx, qz);
      yz <= mulq(qy, qz);
      wx <= mulq(qw, qx);
      wy <= mulq(qw, qy);
      wz <= mulq(qw, qz);

      rm[0] <= ONE_Q30 - ((yy + zz) <<< 1);
      rm[1] <= (xy + wz) <<< 1;
      rm[2] <= (xz - wy) <<< 1;
      rm[3] <= (xy - wz) <<< 1;
      rm[4] <= ONE_Q30 - ((xx + zz) <<< 1);
      rm[5] <= (yz + wx) <<< 1;
      rm[6] <= (xz + wy) <<< 1;
      rm[7] <= (yz - wx) <<< 1;
      rm[8] <= ONE_Q30 - ((xx + yy) <<< 1);

      for (int k = 0; k < 3; k++) begin
        mm[k]   <= scale_q(rm[k],   ctx[Q1+4].scale_x);
        mm[k+3] <= scale_q(rm[k+3], ctx[Q1+4].scale_y);
        mm[k+6] <= scale_q(rm[k+6], UNIT_SCALE);
      end

      mt <= mm;
      for (int r = 0; r < 3; r++) begin
        tp[r*3]   <= cam_term(mm[r*3],   ctx[Q1+5].pos_x);
        tp[r*3+1] <= cam_term(mm[r*3+1], ctx[Q1+5].pos_y);
        tp[r*3+2] <= cam_term(mm[r*3+2], ctx[Q1+5].pos_z);
      end

      if (ctx[Q1+6].action) begin
        outr.m_c0_r0 <= mt[0];
        outr.m_c0_r1 <= mt[3];
        outr.m_c0_r2 <= mt[6];
        outr.m_c1_r0 <= mt[1];
        outr.m_c1_r1 <= mt[4];
        outr.m_c1_r2 <= mt[7];
        outr.m_c2_r0 <= mt[2];
        outr.m_c2_r1 <= mt[5];
        outr.m_c2_r2 <= mt[8];
        outr.trans_x <= sat32(-(66'(tp[0]) + 66'(tp[1]) + 66'(tp[2])));
        outr.trans_y <= sat32(-(66'(tp[3]) + 66'(tp[4]) + 66'(tp[5])));
        outr.trans_z <= sat32(-(66'(tp[6]) + 66'(tp[7]) + 66'(tp[8])));
      end else begin
        outr.m_c0_r0 <= mt[0];
        outr.m_c0_r1 <= mt[1];
        outr.m_c0_r2 <= mt[2];
        outr.m_c1_r0 <= mt[3];
        outr.m_c1_r1 <= mt[4];
        outr.m_c1_r2 <= mt[5];
        outr.m_c2_r0 <= mt[6];
        outr.m_c2_r1 <= mt[7];
        outr.m_c2_r2 <= mt[8];
        outr.trans_x <= ctx[Q1+6].pos_x;
        outr.trans_y <= ctx[Q1+6].pos_y;
        outr.trans_z <= ctx[Q1+6].pos_z;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_rise_from_prev: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld[LAST-1]))
    else $error("result appeared without a request in the last stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[0]) && $stable(vld[Q1]) && $stable(vld[LAST-1]))
    else $error("pipeline moved while stalled");

endmodule
